@@ hdl/dwcsm_pkg.sv @@
// ----------------------------------------------------------------------------
// dwcsm_pkg
// Shared widths, stage payload types and prefix helpers for the step map.
// ----------------------------------------------------------------------------
package dwcsm_pkg;

  localparam int WordBits = 64;
  localparam int LenW     = $clog2(WordBits + 1);
  localparam int CntW     = $clog2(WordBits + 1);
  localparam int HgtW     = $clog2(WordBits) + 2;

  localparam logic signed [HgtW-1:0] HZero   = HgtW'(0);
  localparam logic signed [HgtW-1:0] HOne    = HgtW'(1);
  localparam logic signed [HgtW-1:0] HNegOne = -HgtW'(1);
  localparam logic signed [HgtW-1:0] HNegTwo = -HgtW'(2);

  typedef logic [WordBits-1:0]           word_t;
  typedef logic [WordBits-1:0][CntW-1:0] cnt_vec_t;

  // Position masks from the height scan of the incoming word.
  typedef struct packed {
    word_t word;
    word_t dn0;       // down step at height 0
    word_t qset;      // down step at height 0 or 1
    word_t hp1;       // down step at height 1
    word_t up_h1;     // up step at height 1
    word_t up_hm1;    // up step at height -1
    word_t up_h01;    // up step at height 0 or 1
    word_t up_hm2m1;  // up step at height -2 or -1
  } scan_t;

  typedef struct packed {
    word_t word;
    word_t set_oh;
    logic  found;
    word_t hp1;
    word_t up_h1;
    word_t up_hm1;
    word_t up_h01;
    word_t up_hm2m1;
  } set_t;

  typedef struct packed {
    word_t word;
    word_t set_oh;
    logic  found;
    word_t up1;       // up step at height 1 in the set word
    word_t qclr;      // up step at height 0 or 1 in the set word
  } remap_t;

  // Inclusive running count of set bits, log-depth adder network.
  function automatic cnt_vec_t prefix_count(input word_t m);
    cnt_vec_t c;
    for (int i = 0; i < WordBits; i++) begin
      c[i] = CntW'(m[i]);
    end
    for (int s = 1; s < WordBits; s = s * 2) begin
      for (int i = WordBits - 1; i >= s; i--) begin
        c[i] = c[i] + c[i-s];
      end
    end
    return c;
  endfunction

  function automatic logic [CntW-1:0] popcount(input word_t m);
    cnt_vec_t c;
    c = prefix_count(m);
    return c[WordBits-1];
  endfunction

  // Inclusive running OR toward the high end.
  function automatic word_t prefix_or(input word_t m);
    word_t r;
    r = m;
    for (int s = 1; s < WordBits; s = s * 2) begin
      for (int i = WordBits - 1; i >= s; i--) begin
        r[i] = r[i] | r[i-s];
      end
    end
    return r;
  endfunction

endpackage

@@ hdl/dwcsm_scan.sv @@
// ----------------------------------------------------------------------------
// dwcsm_scan
// Height scan of the word and classification of every position.
// ----------------------------------------------------------------------------
module dwcsm_scan import dwcsm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  stall_o,
  input  word_t word_i,
  input  word_t in_range_i,
  output logic  valid_o,
  input  logic  stall_i,
  output scan_t data_o
);

  cnt_vec_t                incl;
  logic [CntW-1:0]         excl [WordBits];
  logic signed [HgtW-1:0]  hgt  [WordBits];
  word_t                   dn, up;
  scan_t                   data_d, data_q;
  logic                    valid_q;

  always_comb begin
    incl = prefix_count(word_i);
    dn   = ~word_i & in_range_i;
    up   = word_i & in_range_i;
    data_d      = '0;
    data_d.word = word_i;
    for (int i = 0; i < WordBits; i++) begin
      excl[i] = incl[i] - CntW'(word_i[i]);
      hgt[i]  = $signed({1'b0, excl[i][HgtW-3:0], 1'b0}) - $signed(HgtW'(i));
      data_d.dn0[i]      = dn[i] & (hgt[i] == HZero);
      data_d.qset[i]     = dn[i] & ((hgt[i] == HZero) || (hgt[i] == HOne));
      data_d.hp1[i]      = dn[i] & (hgt[i] == HOne);
      data_d.up_h1[i]    = up[i] & (hgt[i] == HOne);
      data_d.up_hm1[i]   = up[i] & (hgt[i] == HNegOne);
      data_d.up_h01[i]   = up[i] & ((hgt[i] == HZero) || (hgt[i] == HOne));
      data_d.up_hm2m1[i] = up[i] & ((hgt[i] == HNegOne) || (hgt[i] == HNegTwo));
    end
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hdl/dwcsm_set.sv @@
// ----------------------------------------------------------------------------
// dwcsm_set
// Pick the down step to set: rank d0+1 among down steps at height 0 or 1.
// ----------------------------------------------------------------------------
module dwcsm_set import dwcsm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  stall_o,
  input  scan_t data_i,
  output logic  valid_o,
  input  logic  stall_i,
  output set_t  data_o
);

  logic [CntW-1:0] target;
  cnt_vec_t        rank;
  set_t            data_d, data_q;
  logic            valid_q;

  always_comb begin
    target = popcount(data_i.dn0) + CntW'(1);
    rank   = prefix_count(data_i.qset);
    data_d = '0;
    for (int i = 0; i < WordBits; i++) begin
      data_d.set_oh[i] = data_i.qset[i] & (rank[i] == target);
    end
    data_d.found    = |data_d.set_oh;
    data_d.word     = data_i.word;
    data_d.hp1      = data_i.hp1;
    data_d.up_h1    = data_i.up_h1;
    data_d.up_hm1   = data_i.up_hm1;
    data_d.up_h01   = data_i.up_h01;
    data_d.up_hm2m1 = data_i.up_hm2m1;
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hdl/dwcsm_remap.sv @@
// ----------------------------------------------------------------------------
// dwcsm_remap
// Rebuild the up-step masks for the word after the set step.
// ----------------------------------------------------------------------------
module dwcsm_remap import dwcsm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   stall_o,
  input  set_t   data_i,
  output logic   valid_o,
  input  logic   stall_i,
  output remap_t data_o
);

  word_t  above;
  remap_t data_d, data_q;
  logic   valid_q;

  // Heights above the set position rise by two; the set position itself
  // becomes an up step at its old height.
  always_comb begin
    above         = prefix_or(data_i.set_oh) & ~data_i.set_oh;
    data_d.word   = data_i.word;
    data_d.set_oh = data_i.set_oh;
    data_d.found  = data_i.found;
    data_d.up1    = (data_i.up_h1 & ~above) | (data_i.up_hm1 & above)
                  | (data_i.set_oh & data_i.hp1);
    data_d.qclr   = (data_i.up_h01 & ~above) | (data_i.up_hm2m1 & above)
                  | data_i.set_oh;
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hdl/dwcsm_clear.sv @@
// ----------------------------------------------------------------------------
// dwcsm_clear
// Clear the u1-th up step at height 0 or 1 and register the result word.
// ----------------------------------------------------------------------------
module dwcsm_clear import dwcsm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   stall_o,
  input  remap_t data_i,
  output logic   valid_o,
  input  logic   stall_i,
  output word_t  word_o,
  output logic   not_found_o
);

  logic [CntW-1:0] u1;
  cnt_vec_t        rank;
  word_t           clr_oh;
  logic            ok;
  word_t           word_d, word_q;
  logic            not_found_q;
  logic            valid_q;

  always_comb begin
    u1   = popcount(data_i.up1);
    rank = prefix_count(data_i.qclr);
    for (int i = 0; i < WordBits; i++) begin
      clr_oh[i] = data_i.qclr[i] & (rank[i] == u1);
    end
    ok     = data_i.found && (|clr_oh);
    word_d = ok ? ((data_i.word | data_i.set_oh) & ~clr_oh) : data_i.word;
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      word_q      <= word_d;
      not_found_q <= !ok;
    end
  end

  assign valid_o     = valid_q;
  assign word_o      = word_q;
  assign not_found_o = not_found_q;

endmodule

@@ hdl/dyck_word_chain_step_map_core.sv @@
// ----------------------------------------------------------------------------
// dyck_word_chain_step_map_core
// Set-then-clear symmetric chain step map on a configurable-length step word.
// ----------------------------------------------------------------------------
// The block reads the low word_length bits of each word as a walk (1 = up,
// 0 = down) and applies one step of the map: set the (d0+1)-th down step that
// starts at height 0 or 1, where d0 counts down steps at height 0, then clear
// the u1-th up step at height 0 or 1 of that new word, where u1 counts its up
// steps at height 1. Bits at and above the length pass through. If either
// step has no candidate, not_found_o is raised and the word comes back as it
// went in. Lengths above 64 act as 64. One word is accepted every cycle while
// no stall holds the input; the result word is carried by five register
// stages (input, height scan, set pick, mask rebuild, clear pick) that each
// take a new word per clock unless stalled. Stall ripples back stage by
// stage, so empty stages keep filling while the output waits.
// Write the length register only while no word is in flight.
// ----------------------------------------------------------------------------
module dyck_word_chain_step_map_core import dwcsm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration
  input  logic                cfg_we_i,
  input  logic [LenW-1:0]     cfg_word_length_i,
  // Input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [WordBits-1:0] word_in_i,
  // Output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [WordBits-1:0] word_out_o,
  output logic                not_found_o
);

  logic [LenW-1:0] len_q;
  logic [LenW-1:0] eff_len;
  word_t           in_range;

  logic   in_valid_q;
  word_t  word_q;

  logic   scan_valid, scan_stall;
  scan_t  scan_data;
  logic   set_valid, set_stall;
  set_t   set_data;
  logic   remap_valid, remap_stall;
  remap_t remap_data;
  logic   clear_stall;

  // Length register; saturate at the word width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenW'(WordBits);
    end else if (cfg_we_i) begin
      len_q <= cfg_word_length_i;
    end
  end

  assign eff_len = (len_q > LenW'(WordBits)) ? LenW'(WordBits) : len_q;

  always_comb begin
    for (int i = 0; i < WordBits; i++) begin
      in_range[i] = LenW'(i) < eff_len;
    end
  end

  // Input register: hold while the scan stage is stalled.
  assign in_stall_o = in_valid_q && scan_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      word_q <= word_in_i;
    end
  end

  // Classify every position by direction and start height.
  dwcsm_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_q),
    .stall_o    (scan_stall),
    .word_i     (word_q),
    .in_range_i (in_range),
    .valid_o    (scan_valid),
    .stall_i    (set_stall),
    .data_o     (scan_data)
  );

  // Pick the down step to set.
  dwcsm_set u_set (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scan_valid),
    .stall_o (set_stall),
    .data_i  (scan_data),
    .valid_o (set_valid),
    .stall_i (remap_stall),
    .data_o  (set_data)
  );

  // Shift heights past the set position and rebuild the up-step masks.
  dwcsm_remap u_remap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (set_valid),
    .stall_o (remap_stall),
    .data_i  (set_data),
    .valid_o (remap_valid),
    .stall_i (clear_stall),
    .data_o  (remap_data)
  );

  // Pick the up step to clear and drive the output register.
  dwcsm_clear u_clear (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (remap_valid),
    .stall_o     (clear_stall),
    .data_i      (remap_data),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .word_o      (word_out_o),
    .not_found_o (not_found_o)
  );

endmodule

@@ hdl/dwcsm_checker.sv @@
// ----------------------------------------------------------------------------
// dwcsm_checker
// Port-level checks for the step map core, bound to the top level.
// ----------------------------------------------------------------------------
module dwcsm_checker import dwcsm_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [WordBits-1:0] word_out_o,
  input logic                not_found_o
);

  // No word leaves during reset.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // Input backpressure only comes from a held result.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output is free");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(word_out_o) && $stable(not_found_o)))
    else $error("output word changed while stalled");

endmodule

bind dyck_word_chain_step_map_core dwcsm_checker u_checker (.*);

@@ tb/dyck_word_chain_step_map_core_test.sv @@
// ----------------------------------------------------------------------------
// dyck_word_chain_step_map_core_test
// Self-checking bench for the set-then-clear symmetric chain step map.
// ----------------------------------------------------------------------------
// A short table of hand-picked words runs first: empty and full walks, tiny
// lengths, odd lengths, saturated lengths and a set that leaves no up step at
// height 1. A long random run follows over several length settings, mostly
// Dyck paths and balanced bridges, with flipped bits and raw noise mixed in.
// Each accepted word is queued with its typed expectation or one mapped by
// an in-bench predictor; every output word is matched in order against that queue.
// ----------------------------------------------------------------------------
module dyck_word_chain_step_map_core_test import dwcsm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // One expected output word and its miss flag.
  typedef struct packed {
    word_t word;
    logic  miss;
  } map_result_t;

  // One directed table row; known marks a hand-typed expectation.
  typedef struct packed {
    logic [LenW-1:0] len;
    word_t           word;
    logic            known;
    word_t           word_exp;
    logic            miss_exp;
  } probe_t;

  localparam int NumProbes = 17;
  localparam int NumPhases = 10;
  localparam int DrainWait = 8;   // five pipeline stages plus margin

  logic            clk_i             = 1'b0;
  logic            rst_ni            = 1'b0;
  logic            cfg_we_i          = 1'b0;
  logic [LenW-1:0] cfg_word_length_i = '0;
  logic            in_valid_i        = 1'b0;
  logic            in_stall_o;
  word_t           word_in_i         = '0;
  logic            out_valid_o;
  logic            out_stall_i       = 1'b0;
  word_t           word_out_o;
  logic            not_found_o;

  // Mirror of the length register; reset value is the full word.
  logic [LenW-1:0] length_now = LenW'(WordBits);
  map_result_t     pending_maps[$];
  map_result_t     due;
  int              errors = 0;
  bit              quiet  = 1'b0;  // no idling on either side when set

  // Directed words. Rows with known = 1 carry an expectation read straight
  // off the map; the rest go through the predictor.
  probe_t probes [NumProbes] = '{
    // all down steps: only one down step at height 0 or 1, so no (d0+1)-th
    '{7'd64,  64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000, 1'b1},
    // all up steps: no down step to set
    '{7'd64,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
    '{7'd64,  64'h5555_5555_5555_5555, 1'b0, '0, 1'b0},
    '{7'd64,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0, 1'b0},
    '{7'd64,  64'h0000_0000_FFFF_FFFF, 1'b0, '0, 1'b0},
    '{7'd64,  64'h8000_0000_0000_0001, 1'b0, '0, 1'b0},
    // up-down becomes down-up over two steps
    '{7'd2,   64'h0000_0000_0000_0001, 1'b1, 64'h0000_0000_0000_0002, 1'b0},
    // same walk, upper bits pass through untouched
    '{7'd2,   64'hFFFF_FFFF_FFFF_FFFD, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0},
    '{7'd2,   64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000, 1'b1},
    // set succeeds but the new word has no up step at height 1
    '{7'd4,   64'h0000_0000_0000_0001, 1'b0, '0, 1'b0},
    // zero length: nothing to scan, word comes back as is
    '{7'd0,   64'hDEAD_BEEF_0123_4567, 1'b1, 64'hDEAD_BEEF_0123_4567, 1'b1},
    '{7'd1,   64'h0000_0000_0000_0000, 1'b0, '0, 1'b0},
    '{7'd1,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0, 1'b0},
    '{7'd7,   64'h0000_0000_0000_0013, 1'b0, '0, 1'b0},
    // lengths above the word width act as the full width
    '{7'd127, 64'h0000_0000_FFFF_FFFF, 1'b0, '0, 1'b0},
    '{7'd65,  64'h5555_5555_5555_5555, 1'b0, '0, 1'b0},
    '{7'd127, 64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000, 1'b1}
  };

  // Length per random phase; -1 picks a random even length.
  int phase_len [NumPhases] = '{64, 2, 6, 127, 0, 1, 65, -1, -1, 64};

  dyck_word_chain_step_map_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_word_length_i (cfg_word_length_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .word_in_i         (word_in_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .word_out_o        (word_out_o),
    .not_found_o       (not_found_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predict one pass of the map over the low len bits of w.
  function automatic map_result_t chain_step(input word_t w, input logic [LenW-1:0] len);
    map_result_t r;
    word_t       y;
    int          n, h, d0, u1, seen, hit;
    r.word = w;
    r.miss = 1'b1;
    n = (int'(len) > WordBits) ? WordBits : int'(len);
    // Set stage: count down steps at height 0, then pick the (d0+1)-th
    // down step at height 0 or 1.
    h  = 0;
    d0 = 0;
    for (int i = 0; i < n; i++) begin
      if (!w[i] && h == 0) d0++;
      h += w[i] ? 1 : -1;
    end
    h    = 0;
    seen = 0;
    hit  = -1;
    for (int i = 0; i < n; i++) begin
      if (!w[i] && (h == 0 || h == 1)) begin
        seen++;
        if (seen == d0 + 1 && hit < 0) hit = i;
      end
      h += w[i] ? 1 : -1;
    end
    if (hit < 0) return r;
    y      = w;
    y[hit] = 1'b1;
    // Clear stage on the set word: count up steps at height 1, then drop the
    // u1-th up step at height 0 or 1. A count of zero never matches.
    h  = 0;
    u1 = 0;
    for (int i = 0; i < n; i++) begin
      if (y[i] && h == 1) u1++;
      h += y[i] ? 1 : -1;
    end
    h    = 0;
    seen = 0;
    hit  = -1;
    for (int i = 0; i < n; i++) begin
      if (y[i] && (h == 0 || h == 1)) begin
        seen++;
        if (seen == u1 && hit < 0) hit = i;
      end
      h += y[i] ? 1 : -1;
    end
    if (hit < 0) return r;
    y[hit] = 1'b0;
    r.word = y;
    r.miss = 1'b0;
    return r;
  endfunction

  // Random word over n steps: mostly Dyck paths and balanced bridges,
  // some with one flipped step, some pure noise. Upper bits stay random.
  function automatic word_t walk_word(input int n);
    word_t w;
    int    h, ups, kind, rem;
    bit    up;
    w    = {$urandom, $urandom};
    kind = $urandom_range(0, 9);
    if (kind >= 8) return w;
    h   = 0;
    ups = n / 2;
    for (int i = 0; i < n; i++) begin
      rem = n - i;
      if (kind < 4 || kind == 6) begin
        // Dyck path: never below zero, return to zero by the end for even n
        if (h == 0) up = 1'b1;
        else if (h >= rem) up = 1'b0;
        else up = 1'($urandom_range(0, 1));
      end else begin
        // bridge: fixed number of up steps, free to dip below zero
        up = ($urandom_range(1, rem) <= ups);
        if (up) ups--;
      end
      w[i] = up;
      h += up ? 1 : -1;
    end
    if ((kind == 6 || kind == 7) && n > 0) begin
      w[$urandom_range(0, n - 1)] ^= 1'b1;
    end
    return w;
  endfunction

  // Offer one word, maybe after an idle burst, and queue its expectation
  // once the block takes it. known selects a typed expectation.
  task automatic offer_word(input word_t w, input bit known, input map_result_t typed);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    word_in_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    pending_maps.push_back(known ? typed : chain_step(w, length_now));
  endtask

  // Drop valid, let every word in flight drain, then write the length.
  task automatic set_length(input logic [LenW-1:0] len);
    in_valid_i <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    cfg_we_i          <= 1'b1;
    cfg_word_length_i <= len;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    length_now  = len;
  endtask

  // Stimulus: reset, directed table, then random phases.
  initial begin
    map_result_t     typed;
    logic [LenW-1:0] len;
    int              n, count;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[k]) begin
      if (probes[k].len != length_now) set_length(probes[k].len);
      typed.word = probes[k].word_exp;
      typed.miss = probes[k].miss_exp;
      offer_word(probes[k].word, probes[k].known, typed);
    end

    for (int p = 0; p < NumPhases; p++) begin
      len = (phase_len[p] < 0) ? LenW'(2 * $urandom_range(1, 31)) : LenW'(phase_len[p]);
      set_length(len);
      // hold both sides busy-free in the closing phase
      if (p == NumPhases - 1) quiet = 1'b1;
      n     = (int'(len) > WordBits) ? WordBits : int'(len);
      count = (n < 2) ? 40 : 210;
      for (int k = 0; k < count; k++) begin
        offer_word(walk_word(n), 1'b0, typed);
      end
    end
    in_valid_i <= 1'b0;

    // Wait for the last word, then give the pipeline time to show extras.
    while (pending_maps.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (errors == 0) begin
      $display("dyck_word_chain_step_map_core_test: clean");
    end else begin
      $display("dyck_word_chain_step_map_core_test: errors");
    end
    $finish;
  end

  // Receiver: free-running stretches broken by stall bursts.
  initial begin
    forever begin
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Check every word the block hands over against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_maps.size() == 0) begin
        $error("word_out: expected none, got %h", word_out_o);
        errors++;
      end else begin
        due = pending_maps.pop_front();
        if (word_out_o !== due.word) begin
          $error("word_out: expected %h, got %h", due.word, word_out_o);
          errors++;
        end
        if (not_found_o !== due.miss) begin
          $error("not_found: expected %b, got %b", due.miss, not_found_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("dyck_word_chain_step_map_core_test: errors");
    $finish;
  end

endmodule

@@ files.f @@
hdl/dwcsm_pkg.sv
hdl/dwcsm_scan.sv
hdl/dwcsm_set.sv
hdl/dwcsm_remap.sv
hdl/dwcsm_clear.sv
hdl/dyck_word_chain_step_map_core.sv
hdl/dwcsm_checker.sv
tb/dyck_word_chain_step_map_core_test.sv
